@@ rtl/scps_pkg.sv @@
package scps_pkg;

    // Sizing
    localparam int MAX_FRAMES = 16;
    localparam int IDX_W      = $clog2(MAX_FRAMES);
    localparam int CNT_W      = IDX_W + 1;
    localparam int PIX_W      = 8;
    localparam int SUM_W      = PIX_W + IDX_W;
    localparam int SQ_W       = 2 * PIX_W + IDX_W;
    localparam int D_W        = SQ_W + CNT_W;
    localparam int RAD_W      = D_W + 8;
    localparam int RAD_W2     = RAD_W + (RAD_W % 2);
    localparam int ROOT_W     = RAD_W2 / 2;
    localparam int REM_W      = ROOT_W + 2;
    localparam int STEP_W     = $clog2(ROOT_W);
    localparam int OUT_W      = 12;
    localparam int CLIP_W     = 8;
    localparam int FC_W       = 5;
    localparam int DELTA_W    = CLIP_W + ROOT_W;
    localparam int BND_W      = DELTA_W + 2;
    localparam int CFG_IDX_W  = 2;
    localparam int OUT_DATA_W = 120;

    localparam logic [FC_W-1:0]   FC_RESET   = 5'd10;
    localparam logic [CLIP_W-1:0] CLIP_RESET = 8'd24;

    // Configuration register map
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_COUNT = 2'd0,
        REG_CLIP_FACTOR = 2'd1
    } cfg_reg_t;

    typedef enum logic {
        ALU_DIV,
        ALU_SQRT
    } alu_op_t;

    // Request into the shared shift-subtract unit
    typedef struct packed {
        logic                  start;
        alu_op_t               op;
        logic [RAD_W2-1:0]     operand;
        logic [CNT_W-1:0]      divisor;
    } alu_req_t;

    typedef enum logic [4:0] {
        ST_LOAD,
        ST_MI,
        ST_MIL,
        ST_MJA,
        ST_MJB,
        ST_MEV,
        ST_MEAN,
        ST_MEAN_W,
        ST_VAR,
        ST_SQ,
        ST_SQ_W,
        ST_SIG,
        ST_SIG_W,
        ST_DELTA,
        ST_BOUND,
        ST_CA,
        ST_CB,
        ST_KDIV,
        ST_KDIV_W,
        ST_OUT
    } state_t;

endpackage

@@ rtl/scps_ram.sv @@
module scps_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/scps_alu.sv @@
// Shared restoring divider / digit-by-digit square root, one bit of result per cycle.
module scps_alu
    import scps_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  alu_req_t          req,
    output logic              done,
    output logic [ROOT_W-1:0] result
);

    logic              busy_reg;
    logic              done_reg;
    alu_op_t           op_reg;
    logic [STEP_W-1:0] step_reg;
    logic [RAD_W2-1:0] opnd_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [ROOT_W-1:0] res_reg;
    logic [CNT_W-1:0]  div_reg;

    logic [REM_W-1:0]  trial;
    logic [REM_W-1:0]  subtrahend;
    logic [REM_W:0]    diff;
    logic              ge;
    logic [REM_W-1:0]  rem_next;
    logic [ROOT_W-1:0] res_next;
    logic [RAD_W2-1:0] opnd_next;

    // One compare-subtract step
    always_comb
    begin
        if (op_reg == ALU_SQRT)
        begin
            trial      = {rem_reg[REM_W-3:0], opnd_reg[RAD_W2-1 -: 2]};
            subtrahend = {res_reg, 2'b01};
            opnd_next  = {opnd_reg[RAD_W2-3:0], 2'b00};
        end
        else
        begin
            trial      = {rem_reg[REM_W-2:0], opnd_reg[RAD_W2-1]};
            subtrahend = REM_W'(div_reg);
            opnd_next  = {opnd_reg[RAD_W2-2:0], 1'b0};
        end
        diff     = {1'b0, trial} - {1'b0, subtrahend};
        ge       = !diff[REM_W];
        rem_next = ge ? diff[REM_W-1:0] : trial;
        res_next = {res_reg[ROOT_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= ALU_DIV;
            step_reg <= '0;
            opnd_reg <= '0;
            rem_reg  <= '0;
            res_reg  <= '0;
            div_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                op_reg   <= req.op;
                step_reg <= '0;
                rem_reg  <= '0;
                res_reg  <= '0;
                div_reg  <= req.divisor;
                if (req.op == ALU_SQRT)
                begin
                    opnd_reg <= req.operand;
                end
                else
                begin
                    opnd_reg <= {req.operand[ROOT_W-1:0], {(RAD_W2-ROOT_W){1'b0}}};
                end
            end
            else if (busy_reg)
            begin
                opnd_reg <= opnd_next;
                rem_reg  <= rem_next;
                res_reg  <= res_next;
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(ROOT_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

@@ rtl/sigma_clipped_pixel_stacker.sv @@
// Sigma-clipped stacker for one pixel position. Each request on the s_ side carries one
// RGB sample; samples load at one per cycle into a 16-entry store. The request that
// brings the frame count up to the configured number closes the pixel, and the block
// then drops s_tready while it works out per channel the mean, median, population sigma
// and the clipped mean over the frames whose three channels all lie within
// median +/- factor*sigma. In closing a pixel, the median is found by a rank pass
// through the single read port of the sample store, the keep pass reads each sample
// once, and the divisions (nine, or six when no frame is kept) and three square roots
// go one after another through one shift-subtract unit, 17 steps each. The result
// sits in an output register, so loading of the next pixel proceeds while it waits
// to be taken. Configuration writes are taken at any time and must only be issued
// while idle.
module sigma_clipped_pixel_stacker
    import scps_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // sample_red [7:0], sample_green [15:8], sample_blue [23:16]
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [23:0]           s_tdata,
    // mean_red/green/blue [35:0], median_red/green/blue [71:36],
    // clipped_red/green/blue [107:72], kept_frames [112:108], none_kept [113], zero pad
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [7:0]            cfg_data
);

    state_t state_reg, state_next;

    logic [FC_W-1:0]   fc_reg;
    logic [CLIP_W-1:0] clip_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [SUM_W-1:0]  sum_reg [3];
    logic [SQ_W-1:0]   sq_reg [3];

    logic [CNT_W-1:0]  i_reg;
    logic [CNT_W-1:0]  j_reg;
    logic [1:0]        ch_reg;
    logic [3*PIX_W-1:0] xi_reg;
    logic [CNT_W-1:0]  less_reg [3];
    logic [CNT_W-1:0]  leq_reg [3];
    logic [PIX_W-1:0]  m1_reg [3];
    logic [PIX_W-1:0]  m2_reg [3];
    logic [OUT_W-1:0]  mean_reg [3];
    logic [OUT_W-1:0]  clipm_reg [3];
    logic [D_W-1:0]    p1_reg;
    logic [D_W-1:0]    p2_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [ROOT_W-1:0] sigma_reg;
    logic [DELTA_W-1:0] delta_reg;
    logic signed [BND_W-1:0] lo_reg [3];
    logic signed [BND_W-1:0] hi_reg [3];
    logic [CNT_W-1:0]  kept_reg;
    logic [SUM_W-1:0]  ksum_reg [3];

    logic                  m_tvalid_reg;
    logic [OUT_DATA_W-1:0] m_tdata_reg;

    logic               load_acc;
    logic [CNT_W-1:0]   n_eff;
    logic [CNT_W-1:0]   idx_inc;
    logic [IDX_W-1:0]   raddr;
    logic [3*PIX_W-1:0] rdata;
    logic [OUT_W-1:0]   med_q4 [3];
    logic [CNT_W-1:0]   k2;
    logic [CNT_W-1:0]   k1;
    logic               keep_ok;
    logic               out_free;
    alu_req_t           alu_req;
    logic               alu_done;
    logic [ROOT_W-1:0]  alu_result;

    scps_ram #(
        .WIDTH(3 * PIX_W),
        .DEPTH(MAX_FRAMES)
    ) u_store (
        .clk   (clk),
        .we    (load_acc),
        .waddr (idx_reg),
        .wdata (s_tdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    scps_alu u_alu (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (alu_req),
        .done   (alu_done),
        .result (alu_result)
    );

    assign s_tready  = (state_reg == ST_LOAD);
    assign load_acc  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign idx_inc   = {1'b0, idx_reg} + 1'b1;
    assign k2        = cnt_reg >> 1;
    assign k1        = k2 - 1'b1;

    // Effective frame count: zero counts as one, large values saturate
    always_comb
    begin
        if (fc_reg == '0)
        begin
            n_eff = CNT_W'(1);
        end
        else if (fc_reg > FC_W'(MAX_FRAMES))
        begin
            n_eff = CNT_W'(MAX_FRAMES);
        end
        else
        begin
            n_eff = CNT_W'(fc_reg);
        end
    end

    // Median in Q4: middle value, or the average of the two middle values
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            if (cnt_reg[0])
            begin
                med_q4[c] = {m2_reg[c], 4'b0000};
            end
            else
            begin
                med_q4[c] = {({1'b0, m1_reg[c]} + {1'b0, m2_reg[c]}), 3'b000};
            end
        end
    end

    // Frame passes when every channel is inside its bounds
    always_comb
    begin
        keep_ok = 1'b1;
        for (int c = 0; c < 3; c++)
        begin
            if (($signed(BND_W'({rdata[8*c +: 8], 8'h00})) < lo_reg[c]) ||
                ($signed(BND_W'({rdata[8*c +: 8], 8'h00})) > hi_reg[c]))
            begin
                keep_ok = 1'b0;
            end
        end
    end

    // Sequencer: next state, store read address and unit requests
    always_comb
    begin
        state_next      = state_reg;
        raddr           = i_reg[IDX_W-1:0];
        alu_req.start   = 1'b0;
        alu_req.op      = ALU_DIV;
        alu_req.operand = '0;
        alu_req.divisor = cnt_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (load_acc && (idx_inc >= n_eff))
                begin
                    state_next = ST_MI;
                end
            end
            ST_MI:
            begin
                state_next = ST_MIL;
            end
            ST_MIL:
            begin
                state_next = ST_MJA;
            end
            ST_MJA:
            begin
                raddr      = j_reg[IDX_W-1:0];
                state_next = ST_MJB;
            end
            ST_MJB:
            begin
                state_next = (j_reg + 1'b1 == cnt_reg) ? ST_MEV : ST_MJA;
            end
            ST_MEV:
            begin
                state_next = (i_reg + 1'b1 == cnt_reg) ? ST_MEAN : ST_MI;
            end
            ST_MEAN:
            begin
                alu_req.start   = 1'b1;
                alu_req.operand = RAD_W2'({sum_reg[ch_reg], 4'b0000});
                state_next      = ST_MEAN_W;
            end
            ST_MEAN_W:
            begin
                if (alu_done)
                begin
                    state_next = ST_VAR;
                end
            end
            ST_VAR:
            begin
                state_next = ST_SQ;
            end
            ST_SQ:
            begin
                alu_req.start   = 1'b1;
                alu_req.op      = ALU_SQRT;
                alu_req.operand = RAD_W2'({(p1_reg - p2_reg), 8'h00});
                state_next      = ST_SQ_W;
            end
            ST_SQ_W:
            begin
                if (alu_done)
                begin
                    state_next = ST_SIG;
                end
            end
            ST_SIG:
            begin
                alu_req.start   = 1'b1;
                alu_req.operand = RAD_W2'(root_reg);
                state_next      = ST_SIG_W;
            end
            ST_SIG_W:
            begin
                if (alu_done)
                begin
                    state_next = ST_DELTA;
                end
            end
            ST_DELTA:
            begin
                state_next = ST_BOUND;
            end
            ST_BOUND:
            begin
                state_next = (ch_reg == 2'd2) ? ST_CA : ST_MEAN;
            end
            ST_CA:
            begin
                state_next = ST_CB;
            end
            ST_CB:
            begin
                state_next = (i_reg + 1'b1 == cnt_reg) ? ST_KDIV : ST_CA;
            end
            ST_KDIV:
            begin
                if (kept_reg == '0)
                begin
                    state_next = (ch_reg == 2'd2) ? ST_OUT : ST_KDIV;
                end
                else
                begin
                    alu_req.start   = 1'b1;
                    alu_req.operand = RAD_W2'({ksum_reg[ch_reg], 4'b0000});
                    alu_req.divisor = kept_reg;
                    state_next      = ST_KDIV_W;
                end
            end
            ST_KDIV_W:
            begin
                if (alu_done)
                begin
                    state_next = (ch_reg == 2'd2) ? ST_OUT : ST_KDIV;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fc_reg   <= FC_RESET;
            clip_reg <= CLIP_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == REG_FRAME_COUNT)
            begin
                fc_reg <= cfg_data[FC_W-1:0];
            end
            else if (cfg_index == REG_CLIP_FACTOR)
            begin
                clip_reg <= cfg_data;
            end
        end
    end

    // Load-side control and running sums
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
            cnt_reg <= CNT_W'(1);
            for (int c = 0; c < 3; c++)
            begin
                sum_reg[c] <= '0;
                sq_reg[c]  <= '0;
            end
        end
        else if (load_acc)
        begin
            for (int c = 0; c < 3; c++)
            begin
                sum_reg[c] <= sum_reg[c] + SUM_W'(s_tdata[8*c +: 8]);
                sq_reg[c]  <= sq_reg[c] + SQ_W'({8'h00, s_tdata[8*c +: 8]} *
                                                {8'h00, s_tdata[8*c +: 8]});
            end
            if (idx_inc >= n_eff)
            begin
                idx_reg <= '0;
                cnt_reg <= idx_inc;
            end
            else
            begin
                idx_reg <= idx_inc[IDX_W-1:0];
            end
        end
        else if ((state_reg == ST_OUT) && out_free)
        begin
            for (int c = 0; c < 3; c++)
            begin
                sum_reg[c] <= '0;
                sq_reg[c]  <= '0;
            end
        end
    end

    // Working registers of the closing sequence
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_LOAD:
            begin
                i_reg  <= '0;
                ch_reg <= '0;
            end
            ST_MIL:
            begin
                xi_reg <= rdata;
                j_reg  <= '0;
                for (int c = 0; c < 3; c++)
                begin
                    less_reg[c] <= '0;
                    leq_reg[c]  <= '0;
                end
            end
            ST_MJB:
            begin
                j_reg <= j_reg + 1'b1;
                for (int c = 0; c < 3; c++)
                begin
                    if (rdata[8*c +: 8] < xi_reg[8*c +: 8])
                    begin
                        less_reg[c] <= less_reg[c] + 1'b1;
                    end
                    if (rdata[8*c +: 8] <= xi_reg[8*c +: 8])
                    begin
                        leq_reg[c] <= leq_reg[c] + 1'b1;
                    end
                end
            end
            ST_MEV:
            begin
                // xi holds rank k when less <= k < leq
                for (int c = 0; c < 3; c++)
                begin
                    if ((less_reg[c] <= k2) && (k2 < leq_reg[c]))
                    begin
                        m2_reg[c] <= xi_reg[8*c +: 8];
                    end
                    if (!cnt_reg[0] && (less_reg[c] <= k1) && (k1 < leq_reg[c]))
                    begin
                        m1_reg[c] <= xi_reg[8*c +: 8];
                    end
                end
                i_reg <= (i_reg + 1'b1 == cnt_reg) ? '0 : i_reg + 1'b1;
            end
            ST_MEAN_W:
            begin
                if (alu_done)
                begin
                    mean_reg[ch_reg] <= alu_result[OUT_W-1:0];
                end
            end
            ST_VAR:
            begin
                p1_reg <= D_W'(cnt_reg) * D_W'(sq_reg[ch_reg]);
                p2_reg <= D_W'(sum_reg[ch_reg]) * D_W'(sum_reg[ch_reg]);
            end
            ST_SQ_W:
            begin
                if (alu_done)
                begin
                    root_reg <= alu_result;
                end
            end
            ST_SIG_W:
            begin
                if (alu_done)
                begin
                    sigma_reg <= alu_result;
                end
            end
            ST_DELTA:
            begin
                delta_reg <= clip_reg * sigma_reg;
            end
            ST_BOUND:
            begin
                lo_reg[ch_reg] <= BND_W'({med_q4[ch_reg], 4'b0000}) - BND_W'(delta_reg);
                hi_reg[ch_reg] <= BND_W'({med_q4[ch_reg], 4'b0000}) + BND_W'(delta_reg);
                ch_reg         <= (ch_reg == 2'd2) ? 2'd0 : ch_reg + 1'b1;
                i_reg          <= '0;
                kept_reg       <= '0;
                for (int c = 0; c < 3; c++)
                begin
                    ksum_reg[c] <= '0;
                end
            end
            ST_CB:
            begin
                if (keep_ok)
                begin
                    kept_reg <= kept_reg + 1'b1;
                    for (int c = 0; c < 3; c++)
                    begin
                        ksum_reg[c] <= ksum_reg[c] + SUM_W'(rdata[8*c +: 8]);
                    end
                end
                i_reg <= i_reg + 1'b1;
            end
            ST_KDIV:
            begin
                if (kept_reg == '0)
                begin
                    clipm_reg[ch_reg] <= '0;
                    ch_reg            <= ch_reg + 1'b1;
                end
            end
            ST_KDIV_W:
            begin
                if (alu_done)
                begin
                    clipm_reg[ch_reg] <= alu_result[OUT_W-1:0];
                    ch_reg            <= ch_reg + 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if ((state_reg == ST_OUT) && out_free)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_OUT) && out_free)
        begin
            m_tdata_reg <= {6'b0, (kept_reg == '0), kept_reg[4:0],
                            clipm_reg[2], clipm_reg[1], clipm_reg[0],
                            med_q4[2], med_q4[1], med_q4[0],
                            mean_reg[2], mean_reg[1], mean_reg[0]};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

@@ rtl/scps_checker.sv @@
module scps_checker
    import scps_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata
);

    // Result held until taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped before taken");

    // Flag agrees with kept count
    a_flag: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[113] == (m_tdata[112:108] == 5'd0)))
        else $error("none_kept disagrees with kept_frames");

    // Nothing kept gives zero clipped means
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[113] |-> (m_tdata[107:72] == 36'd0))
        else $error("clipped means not zero with no frame kept");

    // Means never exceed full scale
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[11:0] <= 12'd4080) && (m_tdata[23:12] <= 12'd4080) &&
                     (m_tdata[35:24] <= 12'd4080))
        else $error("mean out of range");

endmodule

bind sigma_clipped_pixel_stacker scps_checker u_scps_checker (.*);
